>>> rtl/core/sdspi_pkg.sv
// SD SPI command issuer: shared types, constants and the CRC7 byte update.
// Used by every module of the block; depends on nothing.
package sdspi_pkg;

    localparam logic [5:0] APP_PREFIX_INDEX = 6'd55;
    localparam logic [1:0] FRAME_START_BITS = 2'b01;
    localparam logic [6:0] CRC_POLY         = 7'h09;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd10;
    localparam logic [7:0] R1_OK_MAX        = 8'h01;
    localparam logic [2:0] FRAME_LAST_BYTE  = 3'd5;
    localparam logic [2:0] FRAME_CRC_BYTE   = 3'd5;
    localparam logic [2:0] FRAME_CMD_BYTE   = 3'd0;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WAIT = 1'b1;

    localparam logic KIND_FRAME    = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  index;
        logic [31:0] arg;
        logic [7:0]  rx;
        logic        to;
        logic        pf;
    } job_t;

    function automatic logic [6:0] crc7_feed(input logic [6:0] crc_in,
                                             input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = data[i] ^ crc[6];
            crc = {crc[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'h00);
        end
        return crc;
    endfunction

endpackage

>>> rtl/core/sdspi_front.sv
// SD SPI command issuer front end: takes items, tracks the response wait
// and turns each item into at most one job. Depends on sdspi_pkg.
module sdspi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               take,
    input  logic               cmd,
    input  logic [5:0]         cmd_index,
    input  logic               app_cmd,
    input  logic [31:0]        argument,
    input  logic [7:0]         rx_byte,
    output logic               job_push,
    output sdspi_pkg::job_t    job
);
    import sdspi_pkg::*;

    logic        phase_reg, phase_next;
    logic [7:0]  polls_left_reg, polls_left_next;
    logic [5:0]  held_index_reg, held_index_next;
    logic [31:0] held_arg_reg, held_arg_next;
    logic        prefix_reg, prefix_next;
    logic [7:0]  poll_limit_reg;
    logic [7:0]  limit_eff;
    logic [7:0]  polls_dec;
    logic        done;

    assign limit_eff = (poll_limit_reg == 8'd0) ? 8'd1 : poll_limit_reg;
    assign polls_dec = (polls_left_reg != 8'd0) ? polls_left_reg - 8'd1 : 8'd0;
    assign done      = ~rx_byte[7];

    always_comb
    begin
        phase_next      = phase_reg;
        polls_left_next = polls_left_reg;
        held_index_next = held_index_reg;
        held_arg_next   = held_arg_reg;
        prefix_next     = prefix_reg;
        job_push        = 1'b0;
        job             = '0;
        if (take)
        begin
            if (cmd == 1'b0)
            begin
                held_index_next = cmd_index;
                held_arg_next   = argument;
                phase_next      = PH_WAIT;
                polls_left_next = limit_eff;
                prefix_next     = app_cmd;
                job_push        = 1'b1;
                job.kind        = KIND_FRAME;
                job.index       = app_cmd ? APP_PREFIX_INDEX : cmd_index;
                job.arg         = app_cmd ? 32'd0 : argument;
            end
            else if (phase_reg == PH_WAIT)
            begin
                polls_left_next = polls_dec;
                if (done || polls_dec == 8'd0)
                begin
                    job_push = 1'b1;
                    if (prefix_reg && rx_byte <= R1_OK_MAX)
                    begin
                        polls_left_next = limit_eff;
                        prefix_next     = 1'b0;
                        job.kind        = KIND_FRAME;
                        job.index       = held_index_reg;
                        job.arg         = held_arg_reg;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        prefix_next = 1'b0;
                        job.kind    = KIND_RESPONSE;
                        job.rx      = rx_byte;
                        job.to      = ~done;
                        job.pf      = prefix_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            polls_left_reg <= 8'd0;
            held_index_reg <= 6'd0;
            held_arg_reg   <= 32'd0;
            prefix_reg     <= 1'b0;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            polls_left_reg <= polls_left_next;
            held_index_reg <= held_index_next;
            held_arg_reg   <= held_arg_next;
            prefix_reg     <= prefix_next;
            if (cfg_we)
            begin
                poll_limit_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> rtl/core/sdspi_queue.sv
// SD SPI command issuer job queue between front end and frame engine.
// Register-based FIFO of jobs; depends on sdspi_pkg.
module sdspi_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  sdspi_pkg::job_t wr_job,
    input  logic            rd_en,
    output sdspi_pkg::job_t rd_job,
    output logic            q_full,
    output logic            q_empty
);
    import sdspi_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign q_full  = (count_reg == DEPTH_C);
    assign q_empty = (count_reg == '0);
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/sdspi_back.sv
// SD SPI command issuer frame engine: expands jobs into frame bytes with CRC7
// or a response result, into an output register. Depends on sdspi_pkg.
module sdspi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  sdspi_pkg::job_t q_job,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic            out_kind,
    output logic [7:0]      tx_byte,
    output logic            frame_last,
    output logic [7:0]      response,
    output logic            timed_out,
    output logic            prefix_failed
);
    import sdspi_pkg::*;

    logic        busy_reg;
    logic        kind_reg;
    logic [5:0]  index_reg;
    logic [31:0] shift_reg;
    logic [6:0]  crc_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  rx_reg;
    logic        to_reg;
    logic        pf_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_tx_reg;
    logic        out_last_reg;
    logic [7:0]  out_resp_reg;
    logic        out_to_reg;
    logic        out_pf_reg;

    logic        advance;
    logic        emit;
    logic        emit_last;
    logic [7:0]  cur_byte;

    assign advance   = ~out_valid_reg | pop;
    assign emit      = busy_reg & advance;
    assign emit_last = (kind_reg == KIND_RESPONSE) | (cnt_reg == FRAME_LAST_BYTE);
    assign q_pop     = ~q_empty & (~busy_reg | (emit & emit_last));

    always_comb
    begin
        case (cnt_reg)
            FRAME_CMD_BYTE: cur_byte = {FRAME_START_BITS, index_reg};
            FRAME_CRC_BYTE: cur_byte = {crc_reg, 1'b1};
            default:        cur_byte = shift_reg[31:24];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (emit)
            begin
                if (emit_last)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= q_job.kind;
            index_reg <= q_job.index;
            shift_reg <= q_job.arg;
            rx_reg    <= q_job.rx;
            to_reg    <= q_job.to;
            pf_reg    <= q_job.pf;
            crc_reg   <= 7'd0;
        end
        else if (emit)
        begin
            crc_reg <= crc7_feed(crc_reg, cur_byte);
            if (cnt_reg != FRAME_CMD_BYTE)
            begin
                shift_reg <= {shift_reg[23:0], 8'd0};
            end
        end
        if (emit)
        begin
            out_kind_reg <= kind_reg;
            if (kind_reg == KIND_RESPONSE)
            begin
                out_tx_reg   <= 8'd0;
                out_last_reg <= 1'b0;
                out_resp_reg <= rx_reg;
                out_to_reg   <= to_reg;
                out_pf_reg   <= pf_reg;
            end
            else
            begin
                out_tx_reg   <= cur_byte;
                out_last_reg <= (cnt_reg == FRAME_LAST_BYTE);
                out_resp_reg <= 8'd0;
                out_to_reg   <= 1'b0;
                out_pf_reg   <= 1'b0;
            end
        end
    end

    assign empty         = ~out_valid_reg;
    assign out_kind      = out_kind_reg;
    assign tx_byte       = out_tx_reg;
    assign frame_last    = out_last_reg;
    assign response      = out_resp_reg;
    assign timed_out     = out_to_reg;
    assign prefix_failed = out_pf_reg;

endmodule

>>> rtl/core/sd_spi_command_issuer.sv
// SD SPI command issuer top level: front end, job queue and frame engine.
// Depends on sdspi_pkg, sdspi_front, sdspi_queue and sdspi_back.
//
//   channel   ports                                          transfer when
//   input     cmd cmd_index app_cmd argument rx_byte         push & !full
//   result    out_kind tx_byte frame_last response
//             timed_out prefix_failed                        pop & !empty
//   config    cfg_we cfg_wdata (poll_limit)                  cfg_we
//
// A start item yields six frame bytes at one per cycle from the frame engine, while
// the output register is empty or popped, and a response job yields one result.
// Frame engine throughput sets the rate.
// full rises only when the job queue holds QUEUE_DEPTH jobs.
// Reset clears the wait state, the queue and the output register; poll_limit
// returns to 10.
module sd_spi_command_issuer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [5:0]  cmd_index,
    input  logic        app_cmd,
    input  logic [31:0] argument,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        out_kind,
    output logic [7:0]  tx_byte,
    output logic        frame_last,
    output logic [7:0]  response,
    output logic        timed_out,
    output logic        prefix_failed
);
    import sdspi_pkg::*;

    logic take;
    logic job_push;
    job_t job_in;
    job_t job_out;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign full = q_full;
    assign take = push & ~q_full;

    sdspi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .cmd       (cmd),
        .cmd_index (cmd_index),
        .app_cmd   (app_cmd),
        .argument  (argument),
        .rx_byte   (rx_byte),
        .job_push  (job_push),
        .job       (job_in)
    );

    sdspi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .rd_en   (q_pop),
        .rd_job  (job_out),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    sdspi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (job_out),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_kind      (out_kind),
        .tx_byte       (tx_byte),
        .frame_last    (frame_last),
        .response      (response),
        .timed_out     (timed_out),
        .prefix_failed (prefix_failed)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into full queue");

    a_response_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_RESPONSE) |-> (tx_byte == 8'd0 && !frame_last))
        else $error("response result carries frame fields");

    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_FRAME) |->
            (response == 8'd0 && !timed_out && !prefix_failed))
        else $error("frame byte carries response fields");

    a_last_has_end_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_last) |-> tx_byte[0])
        else $error("frame end byte lacks end bit");

endmodule

>>> sim/sd_spi_command_issuer_tb.sv
// Self-checking testbench for sd_spi_command_issuer: queued start and card-byte items in,
// frame bytes and command responses out, checked against an in-bench command predictor.
// Depends on sdspi_pkg and the sd_spi_command_issuer RTL.
module sd_spi_command_issuer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdspi_pkg::*;

    localparam logic CMD_START     = 1'b0;
    localparam logic CMD_CARD_BYTE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  idx;
        logic        app;
        logic [31:0] arg;
        logic [7:0]  rx;
    } issue_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic [7:0] resp;
        logic       to;
        logic       pf;
    } issue_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        push;
    logic        full;
    logic        cmd;
    logic [5:0]  cmd_index;
    logic        app_cmd;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic [7:0]  response;
    logic        timed_out;
    logic        prefix_failed;

    issue_item_t   pending_items[$];
    issue_result_t pending_results[$];

    logic        item_taken;
    logic        calm;
    int          in_gap;
    int          out_gap;
    int          errors;
    int          gen_count;
    int          gen_eff;

    logic        cmd_phase;
    logic [7:0]  cmd_polls_left;
    logic [5:0]  cmd_held_idx;
    logic [31:0] cmd_held_arg;
    logic        cmd_prefix;
    logic [7:0]  cmd_poll_limit;

    sd_spi_command_issuer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .cmd_index     (cmd_index),
        .app_cmd       (app_cmd),
        .argument      (argument),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .out_kind      (out_kind),
        .tx_byte       (tx_byte),
        .frame_last    (frame_last),
        .response      (response),
        .timed_out     (timed_out),
        .prefix_failed (prefix_failed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [7:0] crc7_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data;
        for (int i = 0; i < 8; i++)
        begin
            crc = crc << 1;
            if (d[7] ^ crc[7])
                crc = crc ^ 8'h09;
            d = d << 1;
        end
        return crc;
    endfunction

    task automatic add_result(input logic kind, input logic [7:0] tx, input logic last,
                              input logic [7:0] resp, input logic to, input logic pf);
        issue_result_t r;
        r = '{kind: kind, tx: tx, last: last, resp: resp, to: to, pf: pf};
        pending_results.push_back(r);
    endtask

    task automatic queue_frame(input logic [5:0] idx, input logic [31:0] arg);
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [31:0] a;
        b = {FRAME_START_BITS, idx};
        add_result(KIND_FRAME, b, 1'b0, 8'h00, 1'b0, 1'b0);
        crc = crc7_byte(8'h00, b);
        a = arg;
        for (int i = 0; i < 4; i++)
        begin
            b = a[31:24];
            add_result(KIND_FRAME, b, 1'b0, 8'h00, 1'b0, 1'b0);
            crc = crc7_byte(crc, b);
            a = a << 8;
        end
        b = {crc[6:0], 1'b1};
        add_result(KIND_FRAME, b, 1'b1, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic start_wait(input logic prefix);
        cmd_phase      = PH_WAIT;
        cmd_polls_left = (cmd_poll_limit == 8'd0) ? 8'd1 : cmd_poll_limit;
        cmd_prefix     = prefix;
    endtask

    task automatic predict_command(input issue_item_t it);
        logic done;
        if (it.cmd == CMD_START)
        begin
            cmd_held_idx = it.idx;
            cmd_held_arg = it.arg;
            if (it.app)
            begin
                start_wait(1'b1);
                queue_frame(APP_PREFIX_INDEX, 32'h0);
            end
            else
            begin
                start_wait(1'b0);
                queue_frame(it.idx, it.arg);
            end
        end
        else if (cmd_phase == PH_WAIT)
        begin
            if (cmd_polls_left != 8'd0)
                cmd_polls_left = cmd_polls_left - 8'd1;
            done = !it.rx[7];
            if (done || cmd_polls_left == 8'd0)
            begin
                if (cmd_prefix && it.rx > R1_OK_MAX)
                begin
                    cmd_phase  = PH_IDLE;
                    cmd_prefix = 1'b0;
                    add_result(KIND_RESPONSE, 8'h00, 1'b0, it.rx, !done, 1'b1);
                end
                else if (cmd_prefix)
                begin
                    start_wait(1'b0);
                    queue_frame(cmd_held_idx, cmd_held_arg);
                end
                else
                begin
                    cmd_phase = PH_IDLE;
                    add_result(KIND_RESPONSE, 8'h00, 1'b0, it.rx, !done, 1'b0);
                end
            end
        end
    endtask

    // input side: present the oldest pending item, drop it once transferred
    always @(negedge clk)
    begin
        if (item_taken)
            pending_items.delete(0);
        if (!rst_n || pending_items.size() == 0)
            push <= 1'b0;
        else if (in_gap > 0)
        begin
            in_gap = in_gap - 1;
            push <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 12)
        begin
            in_gap = $urandom_range(0, 10);
            push <= 1'b0;
        end
        else
        begin
            push      <= 1'b1;
            cmd       <= pending_items[0].cmd;
            cmd_index <= pending_items[0].idx;
            app_cmd   <= pending_items[0].app;
            argument  <= pending_items[0].arg;
            rx_byte   <= pending_items[0].rx;
        end
    end

    // result side: stall in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap = out_gap - 1;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 15)
        begin
            out_gap = $urandom_range(0, 10);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        issue_result_t got;
        issue_result_t want;
        got = {out_kind, tx_byte, frame_last, response, timed_out, prefix_failed};
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected result: kind %0d tx %h last %0d resp %h to %0d pf %0d",
                             got.kind, got.tx, got.last, got.resp, got.to, got.pf);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected kind %0d tx %h last %0d resp %h to %0d pf %0d",
                                 want.kind, want.tx, want.last, want.resp, want.to, want.pf);
                        $display("          got      kind %0d tx %h last %0d resp %h to %0d pf %0d",
                                 got.kind, got.tx, got.last, got.resp, got.to, got.pf);
                    end
                end
            end
        end
        item_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
            predict_command(pending_items[0]);
    end

    task automatic add_start(input logic [5:0] idx, input logic app, input logic [31:0] arg);
        issue_item_t it;
        it = '{cmd: CMD_START, idx: idx, app: app, arg: arg, rx: 8'($urandom)};
        pending_items.push_back(it);
        gen_count = gen_count + 1;
    endtask

    task automatic add_card(input logic [7:0] rx);
        issue_item_t it;
        it = '{cmd: CMD_CARD_BYTE, idx: 6'($urandom), app: 1'($urandom), arg: $urandom, rx: rx};
        pending_items.push_back(it);
        gen_count = gen_count + 1;
    endtask

    task automatic add_wait(input logic [7:0] final_rx, input bit time_out);
        int n;
        if (time_out)
            repeat (gen_eff) add_card(8'($urandom_range(128, 255)));
        else
        begin
            n = $urandom_range(0, (gen_eff - 1 < 5) ? gen_eff - 1 : 5);
            repeat (n) add_card(8'($urandom_range(128, 255)));
            add_card(final_rx);
        end
    endtask

    function automatic logic [31:0] pick_arg();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic gen_transaction();
        int   r;
        int   p;
        int   n;
        logic app;
        bit   can_to;
        r      = $urandom_range(0, 99);
        can_to = (gen_eff <= 20);
        if (r < 12)
        begin
            n = $urandom_range(1, 3);
            repeat (n) add_card(8'($urandom));
        end
        else if (r < 25)
        begin
            add_start(6'($urandom), 1'($urandom), pick_arg());
            repeat ($urandom_range(0, (gen_eff - 1 < 3) ? gen_eff - 1 : 3))
                add_card(8'($urandom_range(128, 255)));
        end
        else
        begin
            app = ($urandom_range(0, 9) < 4);
            add_start(6'($urandom), app, pick_arg());
            if (app)
            begin
                p = $urandom_range(0, 9);
                if (p == 9 && can_to)
                begin
                    add_wait(8'hFF, 1'b1);
                    return;
                end
                if (p >= 7)
                begin
                    add_wait(8'($urandom_range(2, 127)), 1'b0);
                    return;
                end
                add_wait(8'($urandom_range(0, 1)), 1'b0);
            end
            if ($urandom_range(0, 9) == 0 && can_to)
                add_wait(8'hFF, 1'b1);
            else
                add_wait(8'($urandom_range(0, 127)), 1'b0);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = gen_count + count;
        while (gen_count < target)
            gen_transaction();
        add_start(6'($urandom), 1'b0, pick_arg());
        add_wait(8'($urandom_range(0, 127)), 1'b0);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        @(negedge clk);
        cfg_we         <= 1'b1;
        cfg_wdata      <= v;
        cmd_poll_limit = v;
        gen_eff        = (v == 8'd0) ? 1 : int'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 8'h00;
        push           = 1'b0;
        cmd            = CMD_START;
        cmd_index      = 6'd0;
        app_cmd        = 1'b0;
        argument       = 32'h0;
        rx_byte        = 8'h00;
        pop            = 1'b0;
        item_taken     = 1'b0;
        calm           = 1'b0;
        in_gap         = 0;
        out_gap        = 0;
        errors         = 0;
        gen_count      = 0;
        gen_eff        = int'(POLL_LIMIT_RESET);
        cmd_phase      = PH_IDLE;
        cmd_polls_left = 8'd0;
        cmd_held_idx   = 6'd0;
        cmd_held_arg   = 32'h0;
        cmd_prefix     = 1'b0;
        cmd_poll_limit = POLL_LIMIT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // card byte while idle, then plain commands at the field extremes
        add_card(8'h00);
        add_start(6'd0, 1'b0, 32'h0000_0000);
        add_card(8'h00);
        add_start(6'd63, 1'b0, 32'hFFFF_FFFF);
        add_card(8'h80);
        add_card(8'h7F);
        // application command: prefix accepted, then prefix rejected
        add_start(6'd41, 1'b1, 32'h40FF_8000);
        add_card(8'h01);
        add_card(8'h00);
        add_start(6'd13, 1'b1, 32'h1234_5678);
        add_card(8'h05);
        // start while waiting: drop the current wait
        add_start(6'd22, 1'b1, 32'hDEAD_BEEF);
        add_start(6'd9, 1'b0, 32'h0000_01AA);
        add_card(8'h00);
        // prefix wait runs out
        add_start(6'd8, 1'b1, 32'h8000_0001);
        add_wait(8'hFF, 1'b1);
        drain();

        set_limit(8'd1);
        run_random(60);
        drain();

        set_limit(8'd255);
        add_start(6'd17, 1'b0, 32'hA5A5_0F0F);
        add_wait(8'($urandom_range(0, 127)), 1'b0);
        run_random(30);
        drain();

        set_limit(8'd0);
        run_random(40);
        drain();

        set_limit(8'($urandom_range(2, 16)));
        run_random(90);
        drain();

        calm = 1'b1;
        set_limit(8'($urandom_range(3, 8)));
        run_random(80);
        drain();

        if (errors == 0)
            $display("sd_spi_command_issuer verification clean");
        else
            $display("sd_spi_command_issuer verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("sd_spi_command_issuer verification failed");
        $finish;
    end

endmodule
